[hdl/tsle_pkg.sv]
// Shared types and constants for the twinkle-star LED effect.
// Used by tsle_ctrl, tsle_datapath and twinkle_star_led_effect.
`default_nettype none
package tsle_pkg;

  localparam int DEF_SLOTS   = 8;
  localparam int DEF_COLUMNS = 32;
  localparam int DEF_ROWS    = 8;

  localparam int COL_W   = 5;
  localparam int ROW_W   = 3;
  localparam int STAGE_W = 11;
  localparam int SPEED_W = 7;
  localparam int CHAN_W  = 8;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int LED_ROW_W = 5;
  localparam int LED_COL_W = 7;

  localparam logic [8:0] DIM_GAIN = 9'd307;

  localparam logic [CHAN_W-1:0]  RST_RED   = 8'd0;
  localparam logic [CHAN_W-1:0]  RST_GREEN = 8'h55;
  localparam logic [CHAN_W-1:0]  RST_BLUE  = 8'hFF;
  localparam logic [STAGE_W-1:0] RST_END   = 11'd1126;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_END   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEL_CENTRE = 3'd0,
    SEL_LEFT   = 3'd1,
    SEL_RIGHT  = 3'd2,
    SEL_UP     = 3'd3,
    SEL_DOWN   = 3'd4
  } emit_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CENTRE,
    S_DIM,
    S_EMIT,
    S_ADVANCE
  } state_t;

  typedef struct packed {
    logic load;
    logic skip;
    logic gain;
    logic centre;
    logic dim;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic live;
    logic last_slot;
    logic emit_done;
  } status_t;

endpackage
`default_nettype wire

[hdl/tsle_ctrl.sv]
// Frame sequencer for the twinkle-star LED effect.
// Depends on tsle_pkg; drives tsle_datapath through cmd_t and reads status_t.
`default_nettype none
module tsle_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  tsle_pkg::status_t status,
  output tsle_pkg::cmd_t   cmd
);
  import tsle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.live) state_next = S_CENTRE;
        else if (status.last_slot) state_next = S_IDLE;
      end
      S_CENTRE: state_next = S_DIM;
      S_DIM:    state_next = S_EMIT;
      S_EMIT: begin
        if (status.emit_done) state_next = S_ADVANCE;
      end
      S_ADVANCE: begin
        state_next = status.last_slot ? S_IDLE : S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SCAN: begin
        cmd.gain = status.live;
        cmd.skip = !status.live;
      end
      S_CENTRE:  cmd.centre  = 1'b1;
      S_DIM:     cmd.dim     = 1'b1;
      S_EMIT:    cmd.emit    = 1'b1;
      S_ADVANCE: cmd.advance = 1'b1;
      default:   busy        = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

[hdl/tsle_datapath.sv]
// Slot store, colour registers, gain and intensity arithmetic, LED word output.
// Depends on tsle_pkg; commanded by tsle_ctrl.
`default_nettype none
module tsle_datapath #(
  parameter int SLOTS   = tsle_pkg::DEF_SLOTS,
  parameter int COLUMNS = tsle_pkg::DEF_COLUMNS,
  parameter int ROWS    = tsle_pkg::DEF_ROWS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  tsle_pkg::cmd_t                        cmd,
  output tsle_pkg::status_t                     status,
  input  wire                                   cfg_write,
  input  wire        [tsle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire        [tsle_pkg::CFG_W-1:0]      cfg_data,
  input  wire        [1:0]                      spawn_count,
  input  wire        [tsle_pkg::COL_W-1:0]      first_column,
  input  wire        [tsle_pkg::ROW_W-1:0]      first_row,
  input  wire        [tsle_pkg::SPEED_W-1:0]    first_speed,
  input  wire        [tsle_pkg::COL_W-1:0]      second_column,
  input  wire        [tsle_pkg::ROW_W-1:0]      second_row,
  input  wire        [tsle_pkg::SPEED_W-1:0]    second_speed,
  output logic                                  strobe,
  output logic signed [tsle_pkg::LED_ROW_W-1:0] led_row,
  output logic signed [tsle_pkg::LED_COL_W-1:0] led_column,
  output logic       [tsle_pkg::CHAN_W-1:0]     red,
  output logic       [tsle_pkg::CHAN_W-1:0]     green,
  output logic       [tsle_pkg::CHAN_W-1:0]     blue,
  output logic                                  off_matrix,
  output logic                                  last
);
  import tsle_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic signed [LED_ROW_W:0] ROWS_S = (LED_ROW_W + 1)'(ROWS);
  localparam logic signed [LED_COL_W:0] COLS_S = (LED_COL_W + 1)'(COLUMNS);

  logic [CHAN_W-1:0]  star_red, star_green, star_blue;
  logic [STAGE_W-1:0] end_stage;

  logic [SLOTS-1:0]   slot_live;
  logic [COL_W-1:0]   slot_column [SLOTS];
  logic [ROW_W-1:0]   slot_row    [SLOTS];
  logic [STAGE_W-1:0] slot_stage  [SLOTS];
  logic [SPEED_W-1:0] slot_speed  [SLOTS];

  logic [IDX_W-1:0]   idx;
  logic [1:0]         taken;
  logic [1:0]         spawns;
  logic [COL_W-1:0]   sp_col   [2];
  logic [ROW_W-1:0]   sp_row   [2];
  logic [SPEED_W-1:0] sp_speed [2];

  logic [STAGE_W-1:0] gain;
  logic [CHAN_W-1:0]  cen_r, cen_g, cen_b;
  logic [CHAN_W-1:0]  dim_r, dim_g, dim_b;
  emit_sel_t          emit_sel;

  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [STAGE_W-1:0] cur_stage;
  logic [SPEED_W-1:0] cur_speed;
  logic [STAGE_W:0]   twice;
  logic [STAGE_W-1:0] gain_next;
  logic [STAGE_W:0]   stage_sum;
  logic [18:0]        prod_r, prod_g, prod_b;
  logic [16:0]        dprod_r, dprod_g, dprod_b;
  logic [SLOTS-1:0]   live_shift;
  logic               live_above;
  logic signed [LED_ROW_W-1:0] row_base, row_out;
  logic signed [LED_COL_W-1:0] col_base, col_out;
  logic               off_next;
  logic               take_spawn;

  assign cur_col   = slot_column[idx];
  assign cur_row   = slot_row[idx];
  assign cur_stage = slot_stage[idx];
  assign cur_speed = slot_speed[idx];

  assign status.live      = slot_live[idx];
  assign status.last_slot = (idx == LAST_IDX);
  assign status.emit_done = (emit_sel == SEL_DOWN);

  always_comb begin
    twice = {cur_stage, 1'b0};
    if (cur_stage < STAGE_W'(512)) begin
      gain_next = twice[STAGE_W-1:0];
    end else if (cur_stage[STAGE_W-1]) begin
      gain_next = '0;
    end else begin
      gain_next = STAGE_W'((STAGE_W + 1)'(2048) - twice);
    end
  end

  assign prod_r  = 19'(star_red)   * 19'(gain);
  assign prod_g  = 19'(star_green) * 19'(gain);
  assign prod_b  = 19'(star_blue)  * 19'(gain);
  assign dprod_r = 17'(cen_r) * 17'(DIM_GAIN);
  assign dprod_g = 17'(cen_g) * 17'(DIM_GAIN);
  assign dprod_b = 17'(cen_b) * 17'(DIM_GAIN);

  assign stage_sum  = {1'b0, cur_stage} + (STAGE_W + 1)'(cur_speed);
  assign live_shift = slot_live >> idx;
  assign live_above = |(live_shift >> 1);
  assign take_spawn = cmd.skip && !slot_live[idx] && (taken < spawns);

  assign row_base = $signed({2'b00, cur_row});
  assign col_base = $signed({2'b00, cur_col});

  always_comb begin
    row_out = row_base;
    col_out = col_base;
    case (emit_sel)
      SEL_LEFT:  col_out = col_base - LED_COL_W'(1);
      SEL_RIGHT: col_out = col_base + LED_COL_W'(1);
      SEL_UP:    row_out = row_base - LED_ROW_W'(1);
      SEL_DOWN:  row_out = row_base + LED_ROW_W'(1);
      default: ;
    endcase
    off_next = (row_out < 0) || ((LED_ROW_W + 1)'(row_out) >= ROWS_S) ||
               (col_out < 0) || ((LED_COL_W + 1)'(col_out) >= COLS_S);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      star_red   <= RST_RED;
      star_green <= RST_GREEN;
      star_blue  <= RST_BLUE;
      end_stage  <= RST_END;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RED:   star_red   <= cfg_data[CHAN_W-1:0];
        REG_GREEN: star_green <= cfg_data[CHAN_W-1:0];
        REG_BLUE:  star_blue  <= cfg_data[CHAN_W-1:0];
        REG_END:   end_stage  <= cfg_data[STAGE_W-1:0];
      endcase
    end
  end

  // frame control and live bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_live <= '0;
      idx       <= '0;
      taken     <= '0;
      spawns    <= '0;
      emit_sel  <= SEL_CENTRE;
      strobe    <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.load) begin
        idx    <= '0;
        taken  <= '0;
        spawns <= (spawn_count == 2'd3) ? 2'd2 : spawn_count;
      end
      if (cmd.skip) begin
        if (take_spawn) begin
          slot_live[idx] <= 1'b1;
          taken          <= taken + 2'd1;
        end
        if (!status.last_slot) idx <= idx + IDX_W'(1);
      end
      if (cmd.dim) emit_sel <= SEL_CENTRE;
      if (cmd.emit && !status.emit_done) emit_sel <= emit_sel_t'(emit_sel + 3'd1);
      if (cmd.advance) begin
        if (stage_sum > {1'b0, end_stage}) slot_live[idx] <= 1'b0;
        if (!status.last_slot) idx <= idx + IDX_W'(1);
      end
    end
  end

  // slot payload and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sp_col[0]   <= first_column;
      sp_row[0]   <= first_row;
      sp_speed[0] <= first_speed;
      sp_col[1]   <= second_column;
      sp_row[1]   <= second_row;
      sp_speed[1] <= second_speed;
    end
    if (take_spawn) begin
      slot_column[idx] <= sp_col[taken[0]];
      slot_row[idx]    <= sp_row[taken[0]];
      slot_speed[idx]  <= sp_speed[taken[0]];
      slot_stage[idx]  <= '0;
    end
    if (cmd.advance && !(stage_sum > {1'b0, end_stage})) begin
      slot_stage[idx] <= stage_sum[STAGE_W-1:0];
    end
    if (cmd.gain) gain <= gain_next;
    if (cmd.centre) begin
      cen_r <= prod_r[17:10];
      cen_g <= prod_g[17:10];
      cen_b <= prod_b[17:10];
    end
    if (cmd.dim) begin
      dim_r <= CHAN_W'(dprod_r[16:10]);
      dim_g <= CHAN_W'(dprod_g[16:10]);
      dim_b <= CHAN_W'(dprod_b[16:10]);
    end
    if (cmd.emit) begin
      led_row    <= row_out;
      led_column <= col_out;
      red        <= (emit_sel == SEL_CENTRE) ? cen_r : dim_r;
      green      <= (emit_sel == SEL_CENTRE) ? cen_g : dim_g;
      blue       <= (emit_sel == SEL_CENTRE) ? cen_b : dim_b;
      off_matrix <= off_next;
      last       <= status.emit_done && !live_above;
    end
  end

endmodule
`default_nettype wire

[hdl/twinkle_star_led_effect.sv]
// Twinkle-star LED effect top level: one frame per start, five LED words per live slot.
// A free slot takes only the scan step; a live slot runs scan, two multiply stages, five words
// and stage advance in turn; busy is high throughout a frame.
// The first word comes soonest when slot 0 is live, later when leading slots are free;
// words cannot be stalled.
// Synchronous reset empties every slot and loads the default colour and end stage.
`default_nettype none
module twinkle_star_led_effect #(
  parameter int SLOTS   = tsle_pkg::DEF_SLOTS,
  parameter int COLUMNS = tsle_pkg::DEF_COLUMNS,
  parameter int ROWS    = tsle_pkg::DEF_ROWS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   start,
  output logic                                  busy,
  input  wire                                   cfg_write,
  input  wire        [tsle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire        [tsle_pkg::CFG_W-1:0]      cfg_data,
  input  wire        [1:0]                      spawn_count,
  input  wire        [tsle_pkg::COL_W-1:0]      first_column,
  input  wire        [tsle_pkg::ROW_W-1:0]      first_row,
  input  wire        [tsle_pkg::SPEED_W-1:0]    first_speed,
  input  wire        [tsle_pkg::COL_W-1:0]      second_column,
  input  wire        [tsle_pkg::ROW_W-1:0]      second_row,
  input  wire        [tsle_pkg::SPEED_W-1:0]    second_speed,
  output logic                                  strobe,
  output logic signed [tsle_pkg::LED_ROW_W-1:0] led_row,
  output logic signed [tsle_pkg::LED_COL_W-1:0] led_column,
  output logic       [tsle_pkg::CHAN_W-1:0]     red,
  output logic       [tsle_pkg::CHAN_W-1:0]     green,
  output logic       [tsle_pkg::CHAN_W-1:0]     blue,
  output logic                                  off_matrix,
  output logic                                  last
);
  import tsle_pkg::*;

  cmd_t    cmd;
  status_t status;

  tsle_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  tsle_datapath #(
    .SLOTS   (SLOTS),
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .spawn_count   (spawn_count),
    .first_column  (first_column),
    .first_row     (first_row),
    .first_speed   (first_speed),
    .second_column (second_column),
    .second_row    (second_row),
    .second_speed  (second_speed),
    .strobe        (strobe),
    .led_row       (led_row),
    .led_column    (led_column),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .off_matrix    (off_matrix),
    .last          (last)
  );

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for twinkle_star_led_effect: drives frame ticks and register writes,
// predicts every LED word in a small scoreboard class and compares them as they appear.
// Depends on tsle_pkg for port widths and the register index enum.
module testbench;
  import tsle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 9 * DEF_SLOTS + 8;
  localparam int DIM_Q10     = 307;

  typedef struct packed {
    logic [LED_ROW_W-1:0] row;
    logic [LED_COL_W-1:0] column;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic                 off;
    logic                 last;
  } led_word_t;

  typedef struct packed {
    logic [1:0]         spawns;
    logic [COL_W-1:0]   col_a;
    logic [ROW_W-1:0]   row_a;
    logic [SPEED_W-1:0] speed_a;
    logic [COL_W-1:0]   col_b;
    logic [ROW_W-1:0]   row_b;
    logic [SPEED_W-1:0] speed_b;
  } frame_t;

  class star_field_board;
    logic [CHAN_W-1:0]  colour_r, colour_g, colour_b;
    logic [STAGE_W-1:0] death_stage;
    bit                 star_live [DEF_SLOTS];
    logic [COL_W-1:0]   star_col [DEF_SLOTS];
    logic [ROW_W-1:0]   star_row [DEF_SLOTS];
    logic [STAGE_W-1:0] star_stage [DEF_SLOTS];
    logic [SPEED_W-1:0] star_speed [DEF_SLOTS];
    led_word_t          led_writes_due[$];
    int                 mismatches;
    int                 words_checked;
    int                 frames_taken;

    function new();
      colour_r = 8'd0;
      colour_g = 8'd85;
      colour_b = 8'd255;
      death_stage = 11'd1126;
      foreach (star_live[i]) star_live[i] = 1'b0;
      mismatches = 0;
      words_checked = 0;
      frames_taken = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_RED:   colour_r = value[CHAN_W-1:0];
        REG_GREEN: colour_g = value[CHAN_W-1:0];
        REG_BLUE:  colour_b = value[CHAN_W-1:0];
        REG_END:   death_stage = value[STAGE_W-1:0];
        default: ;
      endcase
    endfunction

    function led_word_t led_word(int r, int c, int cr, int cg, int cb);
      led_word_t w;
      w.row    = r[LED_ROW_W-1:0];
      w.column = c[LED_COL_W-1:0];
      w.red    = cr[CHAN_W-1:0];
      w.green  = cg[CHAN_W-1:0];
      w.blue   = cb[CHAN_W-1:0];
      w.off    = (r < 0 || r >= DEF_ROWS || c < 0 || c >= DEF_COLUMNS);
      w.last   = 1'b0;
      return w;
    endfunction

    function void note_frame(frame_t f);
      led_word_t frame_words[$];
      int spawns, taken, g, cr, cg, cb, dr, dg, db, r, c, nxt;
      frames_taken++;
      spawns = (f.spawns > 2'd2) ? 2 : int'(f.spawns);
      taken = 0;
      for (int i = 0; i < DEF_SLOTS; i++) begin
        if (star_live[i]) begin
          if (star_stage[i] < 512) g = 2 * int'(star_stage[i]);
          else g = 2048 - 2 * int'(star_stage[i]);
          if (g < 0) g = 0;
          if (g > 1024) g = 1024;
          cr = (int'(colour_r) * g) >> 10;
          cg = (int'(colour_g) * g) >> 10;
          cb = (int'(colour_b) * g) >> 10;
          dr = (cr * DIM_Q10) >> 10;
          dg = (cg * DIM_Q10) >> 10;
          db = (cb * DIM_Q10) >> 10;
          r = int'(star_row[i]);
          c = int'(star_col[i]);
          frame_words.push_back(led_word(r, c, cr, cg, cb));
          frame_words.push_back(led_word(r, c - 1, dr, dg, db));
          frame_words.push_back(led_word(r, c + 1, dr, dg, db));
          frame_words.push_back(led_word(r - 1, c, dr, dg, db));
          frame_words.push_back(led_word(r + 1, c, dr, dg, db));
          nxt = int'(star_stage[i]) + int'(star_speed[i]);
          if (nxt > int'(death_stage)) star_live[i] = 1'b0;
          else star_stage[i] = nxt[STAGE_W-1:0];
        end else if (taken < spawns) begin
          star_col[i]   = (taken == 0) ? f.col_a : f.col_b;
          star_row[i]   = (taken == 0) ? f.row_a : f.row_b;
          star_speed[i] = (taken == 0) ? f.speed_a : f.speed_b;
          star_stage[i] = '0;
          star_live[i]  = 1'b1;
          taken++;
        end
      end
      if (frame_words.size() > 0) frame_words[frame_words.size() - 1].last = 1'b1;
      foreach (frame_words[k]) led_writes_due.push_back(frame_words[k]);
    endfunction

    function void check_write(led_word_t got);
      led_word_t want;
      words_checked++;
      if (led_writes_due.size() == 0) begin
        $error("LED word with nothing expected: row %0d column %0d",
               $signed(got.row), $signed(got.column));
        mismatches++;
        return;
      end
      want = led_writes_due.pop_front();
      if (got.row !== want.row) begin
        $error("led_row: expected %0d, got %0d", $signed(want.row), $signed(got.row));
        mismatches++;
      end
      if (got.column !== want.column) begin
        $error("led_column: expected %0d, got %0d", $signed(want.column), $signed(got.column));
        mismatches++;
      end
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue);
        mismatches++;
      end
      if (got.off !== want.off) begin
        $error("off_matrix: expected %0d, got %0d", want.off, got.off);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int pending();
      return led_writes_due.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic [1:0]           spawn_count = '0;
  logic [COL_W-1:0]     first_column = '0;
  logic [ROW_W-1:0]     first_row = '0;
  logic [SPEED_W-1:0]   first_speed = '0;
  logic [COL_W-1:0]     second_column = '0;
  logic [ROW_W-1:0]     second_row = '0;
  logic [SPEED_W-1:0]   second_speed = '0;

  wire                        busy;
  wire                        strobe;
  wire signed [LED_ROW_W-1:0] led_row;
  wire signed [LED_COL_W-1:0] led_column;
  wire [CHAN_W-1:0]           red;
  wire [CHAN_W-1:0]           green;
  wire [CHAN_W-1:0]           blue;
  wire                        off_matrix;
  wire                        last;

  star_field_board board = new();
  bit steady = 1'b0;
  int cycles = 0;

  twinkle_star_led_effect dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .spawn_count(spawn_count),
    .first_column(first_column), .first_row(first_row), .first_speed(first_speed),
    .second_column(second_column), .second_row(second_row), .second_speed(second_speed),
    .strobe(strobe), .led_row(led_row), .led_column(led_column),
    .red(red), .green(green), .blue(blue), .off_matrix(off_matrix), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe)
      board.check_write({led_row, led_column, red, green, blue, off_matrix, last});
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic frame_t random_frame(bit any_speed);
    frame_t f;
    int roll;
    roll = $urandom_range(0, 99);
    f.spawns  = (roll < 25) ? 2'd0 : (roll < 60) ? 2'd1 : (roll < 85) ? 2'd2 : 2'd3;
    f.col_a   = COL_W'($urandom_range(0, DEF_COLUMNS - 1));
    f.row_a   = ROW_W'($urandom_range(0, DEF_ROWS - 1));
    f.col_b   = COL_W'($urandom_range(0, DEF_COLUMNS - 1));
    f.row_b   = ROW_W'($urandom_range(0, DEF_ROWS - 1));
    f.speed_a = SPEED_W'(any_speed ? $urandom_range(0, 127) : $urandom_range(31, 102));
    f.speed_b = SPEED_W'(any_speed ? $urandom_range(0, 127) : $urandom_range(31, 102));
    return f;
  endfunction

  task automatic send_frame(frame_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    spawn_count   <= f.spawns;
    first_column  <= f.col_a;
    first_row     <= f.row_a;
    first_speed   <= f.speed_a;
    second_column <= f.col_b;
    second_row    <= f.row_b;
    second_speed  <= f.speed_b;
    do @(posedge clk); while (busy);
    board.note_frame(f);
  endtask

  task automatic send_random(int count, bit any_speed);
    for (int i = 0; i < count; i++) send_frame(random_frame(any_speed));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    board.set_reg(idx, value[CFG_W-1:0]);
  endtask

  task automatic reconfigure(int r, int g, int b, int end_at);
    drain();
    write_reg(REG_RED, r);
    write_reg(REG_GREEN, g);
    write_reg(REG_BLUE, b);
    write_reg(REG_END, end_at);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty field, saturated spawn count, corner stars, then let them ramp and die
    send_frame('{2'd0, 5'd0, 3'd0, 7'd31, 5'd0, 3'd0, 7'd31});
    send_frame('{2'd3, 5'd0, 3'd0, 7'd31, 5'd31, 3'd7, 7'd102});
    send_frame('{2'd1, 5'd16, 3'd3, 7'd102, 5'd1, 3'd1, 7'd50});
    send_frame('{2'd2, 5'd0, 3'd7, 7'd64, 5'd31, 3'd0, 7'd77});
    repeat (13) send_frame('{2'd0, 5'd0, 3'd0, 7'd31, 5'd0, 3'd0, 7'd31});
    send_random(40, 1'b0);

    reconfigure(255, 255, 255, 2047);
    send_random(20, 1'b0);
    drain();
    send_random(20, 1'b0);

    reconfigure($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 0);
    send_random(30, 1'b0);

    reconfigure(255, 0, 128, $urandom_range(1, 2046));
    steady = 1'b1;
    send_random(20, 1'b0);
    steady = 1'b0;
    send_random(20, 1'b0);

    reconfigure($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255), 1126);
    send_random(50, 1'b1);

    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d frames over five colour and end-stage settings, %0d LED words compared",
             board.frames_taken, board.words_checked);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
